FILE: design/aff2d_pkg.sv
// Package: constants, command codes, state types and unit structs of the affine unit
`default_nettype none
package aff2d_pkg;

   // Default fixed-point fraction bits and CORDIC length
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // CORDIC working precision and angle constants at CW fraction bits
   localparam int          CW         = 30;
   localparam int          ATAN_LEN   = 24;
   localparam logic [33:0] TWO_PI_W   = 34'd6746518852;
   localparam logic [33:0] PI_W       = 34'd3373259426;
   localparam logic [33:0] HALF_PI_W  = 34'd1686629713;
   localparam logic [33:0] INV_GAIN_W = 34'd652032874;

   // Command codes
   typedef enum logic [3:0] {
      CMD_IDENTITY      = 4'd0,
      CMD_SET_TRANSLATE = 4'd1,
      CMD_SET_ROTATE    = 4'd2,
      CMD_SET_SCALE     = 4'd3,
      CMD_SET_SHEAR     = 4'd4,
      CMD_SET_COMBINED  = 4'd5,
      CMD_CMP_TRANSLATE = 4'd6,
      CMD_CMP_ROTATE    = 4'd7,
      CMD_CMP_SCALE     = 4'd8,
      CMD_CMP_SHEAR     = 4'd9,
      CMD_TRANSFORM     = 4'd10
   } cmd_type;

   // Sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINCOS,
      ST_MUL,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Phases of the sine/cosine unit
   typedef enum logic [2:0] {
      SC_IDLE,
      SC_REDUCE,
      SC_FOLD,
      SC_ROTATE,
      SC_ROUND
   } sc_phase_type;

   // How the operand selector fills the slots for one command
   typedef enum logic [1:0] {
      MODE_LOAD,
      MODE_COMBINED,
      MODE_COMPOSE,
      MODE_POINT
   } mode_type;

   // One multiply-accumulate beat issued by the sequencer
   typedef struct packed {
      logic               valid;
      logic               neg;
      logic               second;
      logic [2:0]         slot;
      logic signed [31:0] add;
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mac_op_type;

   // One finished, saturated slot value
   typedef struct packed {
      logic               valid;
      logic [2:0]         slot;
      logic signed [31:0] value;
      logic               ovf;
   } mac_res_type;

   // Arctangent of 2^-i at CW fraction bits
   function automatic logic [29:0] atan_at(input logic [4:0] i);
      logic [29:0] r;
      unique case (i)
         5'd0:  r = 30'd843314857;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043837;
         5'd3:  r = 30'd133525159;
         5'd4:  r = 30'd67021687;
         5'd5:  r = 30'd33543516;
         5'd6:  r = 30'd16775851;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194283;
         5'd9:  r = 30'd2097149;
         5'd10: r = 30'd1048576;
         5'd11: r = 30'd524288;
         5'd12: r = 30'd262144;
         5'd13: r = 30'd131072;
         5'd14: r = 30'd65536;
         5'd15: r = 30'd32768;
         5'd16: r = 30'd16384;
         5'd17: r = 30'd8192;
         5'd18: r = 30'd4096;
         5'd19: r = 30'd2048;
         5'd20: r = 30'd1024;
         5'd21: r = 30'd512;
         5'd22: r = 30'd256;
         5'd23: r = 30'd128;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/aff2d_if.sv
// Interfaces: command channel and result channel of the affine unit
`default_nettype none
interface aff2d_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         cmd;
   logic signed [31:0] arg_x;
   logic signed [31:0] arg_y;
   logic signed [31:0] arg_angle;
   logic signed [31:0] arg_sx;
   logic signed [31:0] arg_sy;
   logic signed [31:0] arg_ox;
   logic signed [31:0] arg_oy;
   logic               batch_last;

   modport source (output valid, cmd, arg_x, arg_y, arg_angle, arg_sx, arg_sy,
                   arg_ox, arg_oy, batch_last, input ready);
   modport sink   (input valid, cmd, arg_x, arg_y, arg_angle, arg_sx, arg_sy,
                   arg_ox, arg_oy, batch_last, output ready);
endinterface

interface aff2d_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] mat_a;
   logic signed [31:0] mat_b;
   logic signed [31:0] mat_c;
   logic signed [31:0] mat_d;
   logic signed [31:0] mat_tx;
   logic signed [31:0] mat_ty;
   logic               batch_end;
   logic               overflow;

   modport source (output valid, out_x, out_y, mat_a, mat_b, mat_c, mat_d,
                   mat_tx, mat_ty, batch_end, overflow, input ready);
   modport sink   (input valid, out_x, out_y, mat_a, mat_b, mat_c, mat_d,
                   mat_tx, mat_ty, batch_end, overflow, output ready);
endinterface
`default_nettype wire

FILE: design/aff2d_sincos.sv
// Iterative sine/cosine unit: angle reduction by compare-subtract, then CORDIC rotation
`default_nettype none
module aff2d_sincos
   import aff2d_pkg::*;
#(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] angle,
   output logic                    done,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);

   localparam int SHIFT = CW - FRAC_BITS;
   localparam int ZW    = 32 + SHIFT;
   localparam int RW    = ZW + 1;
   localparam int KMAX  = ZW - 33;
   localparam int KW    = $clog2(KMAX + 1);
   localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   localparam logic [RW-1:0]      TWO_PI_R = {{(RW-34){1'b0}}, TWO_PI_W};
   localparam logic signed [34:0] TWO_PI_S = {1'b0, TWO_PI_W};
   localparam logic signed [34:0] PI_S     = {1'b0, PI_W};
   localparam logic signed [34:0] HALF_S   = {1'b0, HALF_PI_W};
   localparam logic signed [33:0] HALF_LSB = 34'sd1 <<< (SHIFT - 1);

   sc_phase_type       phase_ff, phase_in;
   logic [RW-1:0]      mag_ff;
   logic [KW-1:0]      k_ff;
   logic               zneg_ff;
   logic               fneg_ff;
   logic signed [34:0] z_ff;
   logic signed [33:0] x_ff;
   logic signed [33:0] y_ff;
   logic [4:0]         i_ff;

   logic [RW-1:0]      zs;
   logic [RW-1:0]      cand;
   logic [33:0]        resid;
   logic signed [34:0] zf;
   logic               fneg;
   logic signed [33:0] dx, dy;
   logic signed [34:0] atan_s;
   logic signed [33:0] rx, ry;

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         SC_IDLE:   if (start) phase_in = SC_REDUCE;
         SC_REDUCE: if (k_ff == '0) phase_in = SC_FOLD;
         SC_FOLD:   phase_in = SC_ROTATE;
         SC_ROTATE: if (i_ff == 5'(NSTEP - 1)) phase_in = SC_ROUND;
         SC_ROUND:  phase_in = SC_IDLE;
         default:   phase_in = SC_IDLE;
      endcase
   end

   // Shared datapath terms
   always_comb begin
      zs     = {{(RW-32){angle[31]}}, angle} << SHIFT;
      cand   = TWO_PI_R << k_ff;
      resid  = mag_ff[33:0];
      zf     = {1'b0, resid};
      fneg   = 1'b0;
      // fold the residue into [-pi/2, pi/2]
      if (zneg_ff && resid != '0) zf = TWO_PI_S - zf;
      if (zf > PI_S) zf = zf - TWO_PI_S;
      if (zf > HALF_S) begin
         zf   = zf - PI_S;
         fneg = 1'b1;
      end else if (zf < -HALF_S) begin
         zf   = zf + PI_S;
         fneg = 1'b1;
      end
      dx     = y_ff >>> i_ff;
      dy     = x_ff >>> i_ff;
      atan_s = {5'd0, atan_at(i_ff)};
      rx     = (x_ff + HALF_LSB) >>> SHIFT;
      ry     = (y_ff + HALF_LSB) >>> SHIFT;
   end

   // Reduction and rotation registers
   always_ff @(posedge clock) begin
      unique case (phase_ff)
         SC_IDLE: begin
            if (start) begin
               zneg_ff <= zs[RW-1];
               mag_ff  <= zs[RW-1] ? (~zs + 1'b1) : zs;
               k_ff    <= KW'(KMAX);
            end
         end
         SC_REDUCE: begin
            if (mag_ff >= cand) mag_ff <= mag_ff - cand;
            k_ff <= k_ff - 1'b1;
         end
         SC_FOLD: begin
            z_ff    <= zf;
            fneg_ff <= fneg;
            x_ff    <= $signed(INV_GAIN_W);
            y_ff    <= '0;
            i_ff    <= '0;
         end
         SC_ROTATE: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - atan_s;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + atan_s;
            end
            i_ff <= i_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Results are shown during the rounding phase
   assign done    = (phase_ff == SC_ROUND);
   assign cos_out = fneg_ff ? -rx[31:0] : rx[31:0];
   assign sin_out = fneg_ff ? -ry[31:0] : ry[31:0];

endmodule
`default_nettype wire

FILE: design/aff2d_mac.sv
// Shared multiply-accumulate unit: registered product, rounding, sum and saturation
`default_nettype none
module aff2d_mac
   import aff2d_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mac_op_type  op,
   output mac_res_type      res
);

   localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [67:0] MAX32    = 68'sd2147483647;
   localparam logic signed [67:0] MIN32    = -68'sd2147483648;

   logic signed [65:0] p_ff;
   logic               valid_ff;
   logic               neg_ff;
   logic               second_ff;
   logic [2:0]         slot_ff;
   logic signed [31:0] add_ff;
   logic signed [67:0] acc_ff;

   logic signed [65:0] rnd;
   logic signed [66:0] term;
   logic signed [67:0] sum;

   // Product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= op.valid;
      end
      p_ff      <= op.a * op.b;
      neg_ff    <= op.neg;
      second_ff <= op.second;
      slot_ff   <= op.slot;
      add_ff    <= op.add;
   end

   // Round to nearest, ties up, then sign and add
   always_comb begin
      rnd  = (p_ff + HALF_LSB) >>> FRAC_BITS;
      term = neg_ff ? -{rnd[65], rnd} : {rnd[65], rnd};
      sum  = acc_ff + {term[66], term};
   end

   // Hold the first term of a slot
   always_ff @(posedge clock) begin
      if (valid_ff && !second_ff) begin
         acc_ff <= {{36{add_ff[31]}}, add_ff} + {term[66], term};
      end
   end

   // Saturate the finished slot
   always_comb begin
      res.valid = valid_ff && second_ff;
      res.slot  = slot_ff;
      res.ovf   = 1'b0;
      if (sum > MAX32) begin
         res.value = 32'sh7fffffff;
         res.ovf   = 1'b1;
      end else if (sum < MIN32) begin
         res.value = 32'sh80000000;
         res.ovf   = 1'b1;
      end else begin
         res.value = sum[31:0];
      end
   end

endmodule
`default_nettype wire

FILE: design/affine_2d_transform_unit.sv
// Top level: 2D affine matrix unit with sequencer, operand selection and result register
//
// Usage:
//   req_chan carries one command beat (cmd, seven Q arguments, batch_last); a beat
//   is taken when valid and ready are both high. rsp_chan returns one beat per
//   command: the transformed point (zero unless cmd is transform), the matrix as
//   it stands after the command, batch_end and overflow.
//   Every command runs its multiply-accumulate beats through one shared multiplier,
//   two products for each of the six matrix elements and two point coordinates,
//   then passes a drain state and a finish state before the result is registered.
//   Rotation and combined commands first run the sine/cosine unit: angle reduction,
//   a fold step, CORDIC rotation capped at the arctangent table length and rounding.
//   req ready is high only while the sequencer is idle, so one command is worked
//   on at a time; the next can be taken the cycle after the result is registered.
//   A stalled result beat is held in the output register while the next command is
//   taken; a finished command waits in the finish state until that register frees.
//   Reset (synchronous, active high) loads the identity matrix and drops rsp valid.
`default_nettype none
module affine_2d_transform_unit
   import aff2d_pkg::*;
#(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   aff2d_req_if.sink   req_chan,
   aff2d_rsp_if.source rsp_chan
);

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   state_type          state_ff, state_in;
   logic [3:0]         step_ff;
   logic [3:0]         cmd_ff;
   logic signed [31:0] ax_ff, ay_ff, sx_ff, sy_ff, ox_ff, oy_ff;
   logic               last_ff;
   logic signed [31:0] cs_ff, sn_ff;
   logic signed [31:0] elem_ff [6];
   logic signed [31:0] newv_ff [8];
   logic               ovf_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               need_trig;
   logic               rsp_free;
   logic               sc_done;
   logic signed [31:0] sc_cos, sc_sin;
   logic [2:0]         slot;
   logic               sec;
   mode_type           mode;
   logic signed [31:0] lv [6];
   logic signed [32:0] tf [3];
   logic signed [32:0] ts [3];
   logic signed [32:0] nsn;
   mac_op_type         op;
   mac_res_type        res;

   assign accept    = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign need_trig = (req_chan.cmd == CMD_SET_ROTATE) || (req_chan.cmd == CMD_SET_COMBINED)
                      || (req_chan.cmd == CMD_CMP_ROTATE);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign slot = step_ff[3:1];
   assign sec  = step_ff[0];
   assign nsn  = -{sn_ff[31], sn_ff};

   aff2d_sincos #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_sincos (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && need_trig),
      .angle   (req_chan.arg_angle),
      .done    (sc_done),
      .cos_out (sc_cos),
      .sin_out (sc_sin)
   );

   aff2d_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = need_trig ? ST_SINCOS : ST_MUL;
         ST_SINCOS: if (sc_done) state_in = ST_MUL;
         ST_MUL:    if (step_ff == 4'd15) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Capture the command beat, angle results and the step count
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_chan.cmd;
         ax_ff   <= req_chan.arg_x;
         ay_ff   <= req_chan.arg_y;
         sx_ff   <= req_chan.arg_sx;
         sy_ff   <= req_chan.arg_sy;
         ox_ff   <= req_chan.arg_ox;
         oy_ff   <= req_chan.arg_oy;
         last_ff <= req_chan.batch_last;
         cs_ff   <= '0;
         sn_ff   <= '0;
      end
      if (state_ff == ST_SINCOS && sc_done) begin
         cs_ff <= sc_cos;
         sn_ff <= sc_sin;
      end
      if (state_ff == ST_MUL) begin
         step_ff <= step_ff + 1'b1;
      end else begin
         step_ff <= '0;
      end
   end

   // Decode the command into a slot filling mode and its operand vectors
   always_comb begin
      mode = MODE_LOAD;
      for (int e = 0; e < 6; e++) lv[e] = elem_ff[e];
      for (int e = 0; e < 3; e++) begin
         tf[e] = '0;
         ts[e] = '0;
      end
      unique case (cmd_ff)
         CMD_IDENTITY:      lv = '{ONE, '0, '0, ONE, '0, '0};
         CMD_SET_TRANSLATE: lv = '{ONE, '0, '0, ONE, ax_ff, ay_ff};
         CMD_SET_ROTATE:    lv = '{cs_ff, sn_ff, nsn[31:0], cs_ff, '0, '0};
         CMD_SET_SCALE:     lv = '{sx_ff, '0, '0, sy_ff, '0, '0};
         CMD_SET_SHEAR:     lv = '{ONE, ay_ff, ax_ff, ONE, '0, '0};
         CMD_SET_COMBINED:  mode = MODE_COMBINED;
         CMD_CMP_TRANSLATE: begin
            mode = MODE_COMPOSE;
            tf   = '{{ONE[31], ONE}, '0, {ax_ff[31], ax_ff}};
            ts   = '{'0, {ONE[31], ONE}, {ay_ff[31], ay_ff}};
         end
         CMD_CMP_ROTATE: begin
            mode = MODE_COMPOSE;
            tf   = '{{cs_ff[31], cs_ff}, nsn, '0};
            ts   = '{{sn_ff[31], sn_ff}, {cs_ff[31], cs_ff}, '0};
         end
         CMD_CMP_SCALE: begin
            mode = MODE_COMPOSE;
            tf   = '{{sx_ff[31], sx_ff}, '0, '0};
            ts   = '{'0, {sy_ff[31], sy_ff}, '0};
         end
         CMD_CMP_SHEAR: begin
            mode = MODE_COMPOSE;
            tf   = '{{ONE[31], ONE}, {ax_ff[31], ax_ff}, '0};
            ts   = '{{ay_ff[31], ay_ff}, {ONE[31], ONE}, '0};
         end
         CMD_TRANSFORM:     mode = MODE_POINT;
         default:           mode = MODE_LOAD;
      endcase
   end

   // Select the operands of the current multiply-accumulate beat
   always_comb begin
      op.valid  = (state_ff == ST_MUL);
      op.neg    = 1'b0;
      op.second = sec;
      op.slot   = slot;
      op.add    = '0;
      op.a      = '0;
      op.b      = '0;
      unique case (mode)
         MODE_LOAD: begin
            if (slot < 3'd6) op.add = lv[slot];
         end
         MODE_COMBINED: begin
            unique case (slot)
               3'd0: if (!sec) begin
                  op.a = {cs_ff[31], cs_ff};
                  op.b = {sx_ff[31], sx_ff};
               end
               3'd1: if (!sec) begin
                  op.a = {sn_ff[31], sn_ff};
                  op.b = {sx_ff[31], sx_ff};
               end
               3'd2: if (!sec) begin
                  op.a   = {sn_ff[31], sn_ff};
                  op.b   = {sy_ff[31], sy_ff};
                  op.neg = 1'b1;
               end
               3'd3: if (!sec) begin
                  op.a = {cs_ff[31], cs_ff};
                  op.b = {sy_ff[31], sy_ff};
               end
               3'd4: begin
                  // tx uses the saturated a and c of this command
                  op.add = ax_ff;
                  op.neg = 1'b1;
                  op.a   = sec ? {oy_ff[31], oy_ff} : {ox_ff[31], ox_ff};
                  op.b   = sec ? {newv_ff[2][31], newv_ff[2]} : {newv_ff[0][31], newv_ff[0]};
               end
               3'd5: begin
                  op.add = ay_ff;
                  op.neg = 1'b1;
                  op.a   = sec ? {oy_ff[31], oy_ff} : {ox_ff[31], ox_ff};
                  op.b   = sec ? {newv_ff[3][31], newv_ff[3]} : {newv_ff[1][31], newv_ff[1]};
               end
               default: ;
            endcase
         end
         MODE_COMPOSE: begin
            if (slot < 3'd6) begin
               op.a = sec ? (slot[0] ? {elem_ff[3][31], elem_ff[3]}
                                     : {elem_ff[2][31], elem_ff[2]})
                          : (slot[0] ? {elem_ff[1][31], elem_ff[1]}
                                     : {elem_ff[0][31], elem_ff[0]});
               op.b = sec ? ts[slot[2:1]] : tf[slot[2:1]];
               if (slot == 3'd4) op.add = elem_ff[4];
               if (slot == 3'd5) op.add = elem_ff[5];
            end
         end
         MODE_POINT: begin
            if (slot < 3'd6) begin
               op.add = elem_ff[slot];
            end else begin
               op.a   = sec ? (slot[0] ? {elem_ff[3][31], elem_ff[3]}
                                       : {elem_ff[2][31], elem_ff[2]})
                            : (slot[0] ? {elem_ff[1][31], elem_ff[1]}
                                       : {elem_ff[0][31], elem_ff[0]});
               op.b   = sec ? {ay_ff[31], ay_ff} : {ax_ff[31], ax_ff};
               op.add = slot[0] ? elem_ff[5] : elem_ff[4];
            end
         end
         default: ;
      endcase
   end

   // Collect finished slots and overflow
   always_ff @(posedge clock) begin
      if (accept) ovf_ff <= 1'b0;
      if (res.valid) begin
         newv_ff[res.slot] <= res.value;
         if (res.ovf) ovf_ff <= 1'b1;
      end
   end

   // Commit the matrix and register the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff      <= '{ONE, '0, '0, ONE, '0, '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && rsp_free) begin
            for (int e = 0; e < 6; e++) elem_ff[e] <= newv_ff[e];
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_chan.out_x     <= newv_ff[6];
         rsp_chan.out_y     <= newv_ff[7];
         rsp_chan.mat_a     <= newv_ff[0];
         rsp_chan.mat_b     <= newv_ff[1];
         rsp_chan.mat_c     <= newv_ff[2];
         rsp_chan.mat_d     <= newv_ff[3];
         rsp_chan.mat_tx    <= newv_ff[4];
         rsp_chan.mat_ty    <= newv_ff[5];
         rsp_chan.batch_end <= last_ff;
         rsp_chan.overflow  <= ovf_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: design/aff2d_checker.sv
// Checker: port-level assertions on the affine unit, bound to the top level
`default_nettype none
module aff2d_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // One command at a time: ready drops after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req ready stayed high after an accepted beat");

   // A result never appears the cycle after a command is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after acceptance");

   // A stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled result beat dropped");

   // Reset clears the result register
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind affine_2d_transform_unit aff2d_checker u_aff2d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
`default_nettype wire
